/* hw/rtl/cdg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package cdg_pkg;
  typedef enum logic [1:0] {
    MODE_DEPOSIT = 2'd0,
    MODE_READ    = 2'd1,
    MODE_SUM     = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_t;

  localparam int unsigned REG_DEPOSIT_WEIGHT  = 0;
  localparam int unsigned REG_EMPTY_THRESHOLD = 1;
  localparam logic [31:0] WEIGHT_RESET    = 32'd65536;
  localparam logic [31:0] THRESHOLD_RESET = 32'd1;
  localparam logic [31:0] DENS_MAX        = 32'hFFFF_FFFF;
endpackage
`default_nettype wire

/* hw/rtl/cdg_grid_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
module cdg_grid_mem #(
  parameter int AW = 15
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);
  logic [31:0] mem [0:(1<<AW)-1];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hw/rtl/cic_density_grid_3d_unit.sv */
// Operation: deposit spreads the weight over 8 corners, each through three multiplies,
// read, wait and write back, then the result is output; read fetches one cell; summarize
// scans all G^3 cells; clear returns its item first, then wipes G^3 cells.
// Throughput: one item at a time; the next item is taken once the result has left.
// Reset: synchronous active-low rst_n; a clearing pass over all G^3 cells runs
// after reset while no item is accepted. Registers return to their defaults.
`timescale 1ns / 1ps
`default_nettype none
module cic_density_grid_3d_unit #(
  parameter int GRID_BITS = 5,
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // mode[1:0], pos_x[33:2], pos_y[65:34], pos_z[97:66], cell_req[112:98]
  input  wire logic [119:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // density[31:0], min_cell[46:32], max_cell[61:47], empty_count[77:62],
  // filled_count[93:78]
  output logic [95:0]       out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [31:0]  cfg_wdata
);
  import cdg_pkg::*;

  localparam int AW = 3 * GRID_BITS;
  localparam int NC = 1 << AW;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DMUL0, S_DMUL1, S_DMUL2, S_DRD, S_DWAIT, S_DWR,
    S_RWAIT, S_RDONE, S_SRD, S_SACC, S_OUT
  } state_t;

  state_t state_r;
  logic [31:0] weight_r, thresh_r;
  logic [1:0] mode_r;
  logic [GRID_BITS-1:0] cx_r, cy_r, cz_r;
  logic [FRAC_BITS-1:0] fx_r, fy_r, fz_r;
  logic [2:0] corner_r;
  logic [AW:0] cnt_r;
  logic [AW-1:0] addr_r;
  logic [47:0] amt_r;
  logic [31:0] dens_r, minv_r, maxv_r;
  logic [AW-1:0] imin_r, imax_r;
  logic [AW:0] empty_r, filled_r;
  logic [31:0] rdata;
  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0] mem_wdata;

  cdg_grid_mem #(.AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(rdata)
  );

  // corner weights and wrapped coordinates
  logic [FRAC_BITS:0] wx, wy, wz;
  logic [GRID_BITS-1:0] nx, ny, nz;
  always_comb begin
    wx = corner_r[2] ? {1'b0, fx_r} : (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, fx_r};
    wy = corner_r[1] ? {1'b0, fy_r} : (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, fy_r};
    wz = corner_r[0] ? {1'b0, fz_r} : (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, fz_r};
    nx = cx_r + GRID_BITS'(corner_r[2]);
    ny = cy_r + GRID_BITS'(corner_r[1]);
    nz = cz_r + GRID_BITS'(corner_r[0]);
  end

  // one multiply per cycle; the product is truncated after each axis
  logic [47:0] mul_a;
  logic [FRAC_BITS:0] mul_b;
  logic [48+FRAC_BITS:0] prod;
  always_comb begin
    unique case (state_r)
      S_DMUL1: mul_b = wy;
      S_DMUL2: mul_b = wz;
      default: mul_b = wx;
    endcase
    mul_a = (state_r == S_DMUL0) ? 48'(weight_r) : amt_r;
    prod = (49+FRAC_BITS)'(mul_a) * (49+FRAC_BITS)'(mul_b);
  end
  logic [47:0] prod_sh;
  assign prod_sh = 48'(prod >> FRAC_BITS);

  logic [32:0] sum;
  assign sum = {1'b0, rdata} + {1'b0, amt_r[31:0]};

  // memory port use
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = '0;
    mem_raddr = addr_r;
    unique case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_waddr = cnt_r[AW-1:0];
      end
      S_DWR: begin
        mem_we = 1'b1;
        mem_wdata = sum[32] ? DENS_MAX : sum[31:0];
      end
      S_SRD, S_SACC: mem_raddr = cnt_r[AW-1:0];
      default: ;
    endcase
  end

  logic [31:0] mv;
  assign mv = rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r <= '0;
      weight_r <= WEIGHT_RESET;
      thresh_r <= THRESHOLD_RESET;
      out_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'(REG_DEPOSIT_WEIGHT)) weight_r <= cfg_wdata;
        else thresh_r <= cfg_wdata;
      end
      unique case (state_r)
        S_CLR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == (AW+1)'(NC - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            mode_r <= in_tdata[1:0];
            cx_r <= in_tdata[33 -: GRID_BITS];
            fx_r <= in_tdata[33-GRID_BITS -: FRAC_BITS];
            cy_r <= in_tdata[65 -: GRID_BITS];
            fy_r <= in_tdata[65-GRID_BITS -: FRAC_BITS];
            cz_r <= in_tdata[97 -: GRID_BITS];
            fz_r <= in_tdata[97-GRID_BITS -: FRAC_BITS];
            addr_r <= AW'(in_tdata[112:98]);
            dens_r <= '0;
            cnt_r <= '0;
            corner_r <= '0;
            empty_r <= '0;
            filled_r <= '0;
            imin_r <= '0;
            imax_r <= '0;
            unique case (mode_t'(in_tdata[1:0]))
              MODE_DEPOSIT: state_r <= S_DMUL0;
              MODE_READ: state_r <= S_RWAIT;
              MODE_SUM: state_r <= S_SRD;
              MODE_CLEAR: state_r <= S_CLR;
            endcase
            if (mode_t'(in_tdata[1:0]) == MODE_CLEAR) out_tvalid <= 1'b1;
          end
        end
        S_DMUL0: begin
          amt_r <= prod_sh;
          state_r <= S_DMUL1;
        end
        S_DMUL1: begin
          amt_r <= prod_sh;
          state_r <= S_DMUL2;
        end
        S_DMUL2: begin
          amt_r <= prod_sh;
          addr_r <= {nx, ny, nz};
          state_r <= S_DRD;
        end
        S_DRD: state_r <= S_DWAIT;
        S_DWAIT: state_r <= S_DWR;
        S_DWR: begin
          corner_r <= corner_r + 1'b1;
          if (corner_r == 3'd7) state_r <= S_OUT;
          else state_r <= S_DMUL0;
        end
        S_RWAIT: state_r <= S_RDONE;
        S_RDONE: begin
          dens_r <= rdata;
          state_r <= S_OUT;
        end
        S_SRD: begin
          cnt_r <= cnt_r + 1'b1;
          state_r <= S_SACC;
        end
        S_SACC: begin
          // rdata holds cell cnt_r-1
          if (cnt_r == (AW+1)'(1)) begin
            minv_r <= mv;
            maxv_r <= mv;
          end else begin
            if (mv < minv_r) begin
              minv_r <= mv;
              imin_r <= AW'(cnt_r - 1'b1);
            end
            if (mv > maxv_r) begin
              maxv_r <= mv;
              imax_r <= AW'(cnt_r - 1'b1);
            end
          end
          if (mv > thresh_r) filled_r <= filled_r + 1'b1;
          else empty_r <= empty_r + 1'b1;
          if (cnt_r == (AW+1)'(NC)) state_r <= S_OUT;
          else cnt_r <= cnt_r + 1'b1;
        end
        S_OUT: begin
          out_tvalid <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
    end
  end

  // accept only when idle and no result waits
  assign in_tready = (state_r == S_IDLE) && !out_tvalid;

  logic sum_mode;
  assign sum_mode = (mode_r == MODE_SUM);
  always_comb begin
    out_tdata = '0;
    out_tdata[31:0] = dens_r;
    if (sum_mode) begin
      out_tdata[46:32] = 15'(imin_r);
      out_tdata[61:47] = 15'(imax_r);
      out_tdata[77:62] = 16'(empty_r);
      out_tdata[93:78] = 16'(filled_r);
    end
  end
endmodule
`default_nettype wire

/* verif/tb_cic_density_grid_3d_unit.sv */
`timescale 1ns / 1ps
module tb_cic_density_grid_3d_unit;
  import cdg_pkg::*;

  localparam int GB     = 5;
  localparam int FB     = 16;
  localparam int GN     = 1 << GB;
  localparam int NCELLS = 1 << (3 * GB);

  typedef struct packed {
    logic [15:0] filled_count;
    logic [15:0] empty_count;
    logic [14:0] max_cell;
    logic [14:0] min_cell;
    logic [31:0] density;
  } grid_res_t;

  // Grid predictor and queue of pending results
  class grid_scoreboard;
    logic [31:0] cells [NCELLS];
    logic [31:0] weight;
    logic [31:0] threshold;
    grid_res_t   pending [$];
    int          errors;

    function void reset_state();
      foreach (cells[i]) cells[i] = '0;
      weight    = WEIGHT_RESET;
      threshold = THRESHOLD_RESET;
      pending.delete();
      errors = 0;
    endfunction

    function void write_reg(int idx, logic [31:0] val);
      if (idx == REG_DEPOSIT_WEIGHT) weight = val;
      else if (idx == REG_EMPTY_THRESHOLD) threshold = val;
    endfunction

    function void add_cell(int idx, logic [63:0] amt);
      logic [63:0] s;
      s = {32'd0, cells[idx]} + amt;
      cells[idx] = (s > 64'hFFFF_FFFF) ? DENS_MAX : s[31:0];
    endfunction

    // Spread one particle over its eight neighbouring cells
    function void scatter(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      logic [GB-1:0] cx, cy, cz, nx, ny, nz;
      logic [63:0]   fx, fy, fz, wx, wy, wz, ax, ay, az;
      cx = px[31 -: GB]; fx = 64'(px[31-GB -: FB]);
      cy = py[31 -: GB]; fy = 64'(py[31-GB -: FB]);
      cz = pz[31 -: GB]; fz = 64'(pz[31-GB -: FB]);
      for (int jx = 0; jx < 2; jx++) begin
        wx = jx ? fx : (64'd1 << FB) - fx;
        nx = cx + GB'(jx);
        ax = ({32'd0, weight} * wx) >> FB;
        for (int jy = 0; jy < 2; jy++) begin
          wy = jy ? fy : (64'd1 << FB) - fy;
          ny = cy + GB'(jy);
          ay = (ax * wy) >> FB;
          for (int jz = 0; jz < 2; jz++) begin
            wz = jz ? fz : (64'd1 << FB) - fz;
            nz = cz + GB'(jz);
            az = (ay * wz) >> FB;
            add_cell(int'({nx, ny, nz}), az);
          end
        end
      end
    endfunction

    function void note_item(logic [119:0] d);
      grid_res_t r;
      int imin, imax, nempty, nfill;
      r = '0;
      case (mode_t'(d[1:0]))
        MODE_DEPOSIT: scatter(d[33:2], d[65:34], d[97:66]);
        MODE_READ:    r.density = cells[d[98 +: 3*GB]];
        MODE_SUM: begin
          imin = 0; imax = 0; nempty = 0; nfill = 0;
          for (int i = 0; i < NCELLS; i++) begin
            if (cells[i] < cells[imin]) imin = i;
            if (cells[i] > cells[imax]) imax = i;
            if (cells[i] > threshold) nfill++;
            else nempty++;
          end
          r.min_cell = 15'(imin); r.max_cell = 15'(imax);
          r.empty_count = 16'(nempty); r.filled_count = 16'(nfill);
        end
        default: foreach (cells[i]) cells[i] = '0;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(logic [95:0] d);
      grid_res_t got, want;
      got = d[93:0];
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h", $time, d);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.density !== want.density)
        $display("%0t density exp %h got %h", $time, want.density, got.density);
      if (got.min_cell !== want.min_cell)
        $display("%0t min_cell exp %0d got %0d", $time, want.min_cell, got.min_cell);
      if (got.max_cell !== want.max_cell)
        $display("%0t max_cell exp %0d got %0d", $time, want.max_cell, got.max_cell);
      if (got.empty_count !== want.empty_count)
        $display("%0t empty_count exp %0d got %0d", $time, want.empty_count,
                 got.empty_count);
      if (got.filled_count !== want.filled_count)
        $display("%0t filled_count exp %0d got %0d", $time, want.filled_count,
                 got.filled_count);
      if (got !== want || d[95:94] !== 2'b00) errors++;
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [119:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [95:0]  out_tdata;
  logic         cfg_we = 0;
  logic [0:0]   cfg_index = '0;
  logic [31:0]  cfg_wdata = '0;

  int send_idle = 0;
  int recv_stall = 0;
  grid_scoreboard sb;

  cic_density_grid_3d_unit #(.GRID_BITS(GB), .FRAC_BITS(FB)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver: stall at random, check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  // Hold tvalid between back-to-back items; drop it only while idling
  task automatic send_item(mode_t m, logic [31:0] px, logic [31:0] py,
                           logic [31:0] pz, logic [14:0] req);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {7'd0, req, pz, py, px, m};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_item(in_tdata);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    while (!in_tready) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= 1'(idx);
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random mix of all modes; half the deposits cluster near the origin so cells fill and summaries vary
  task automatic random_item();
    int r;
    logic [31:0] px, py, pz;
    r  = $urandom_range(99);
    px = $urandom(); py = $urandom(); pz = $urandom();
    if ($urandom_range(1)) begin
      px[31:29] = 0; py[31:29] = 0; pz[31:29] = 0;
    end
    if (r < 60) send_item(MODE_DEPOSIT, px, py, pz, 15'($urandom()));
    else if (r < 88)
      send_item(MODE_READ, $urandom(), $urandom(), $urandom(),
                $urandom_range(1) ? 15'($urandom()) : 15'($urandom_range(1023)));
    else if (r < 98)
      send_item(MODE_SUM, $urandom(), $urandom(), $urandom(), 15'($urandom()));
    else send_item(MODE_CLEAR, $urandom(), $urandom(), $urandom(), 15'($urandom()));
  endtask

  initial begin
    int idle_s [4] = '{0, 77, 0, 14};
    int idle_r [4] = '{0, 0, 77, 14};
    logic [31:0] wts [4] = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'h0003_0000};
    logic [31:0] ths [4] = '{32'd0, 32'hFFFF_FFFF, 32'h0000_8000, 32'd1};
    sb = new();
    sb.reset_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every mode, wrap and saturation
    send_item(MODE_SUM, 0, 0, 0, 0);
    send_item(MODE_DEPOSIT, 0, 0, 0, 0);
    send_item(MODE_DEPOSIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'h7FFF);
    send_item(MODE_DEPOSIT, 32'h0400_8000, 32'hF800_0000, 32'h07FF_F800, 0);
    send_item(MODE_READ, 0, 0, 0, 0);
    send_item(MODE_READ, 0, 0, 0, 15'h7FFF);
    send_item(MODE_READ, 0, 0, 0, 15'h0421);
    send_item(MODE_SUM, 0, 0, 0, 0);
    send_item(MODE_CLEAR, 0, 0, 0, 0);
    send_item(MODE_SUM, 0, 0, 0, 0);
    drain();
    write_reg(REG_DEPOSIT_WEIGHT, 32'hFFFF_FFFF);
    write_reg(REG_EMPTY_THRESHOLD, 32'd0);
    for (int k = 0; k < 4; k++)
      send_item(MODE_DEPOSIT, 32'h0800_0000, 32'h0800_0000, 32'h0800_0000, 0);
    send_item(MODE_READ, 0, 0, 0, 15'h0421);
    send_item(MODE_SUM, 0, 0, 0, 0);
    send_item(MODE_CLEAR, 0, 0, 0, 0);
    drain();

    // Random phases with different registers and idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_DEPOSIT_WEIGHT, (ph < 4) ? wts[ph] : $urandom());
      write_reg(REG_EMPTY_THRESHOLD, (ph < 4) ? ths[ph] : $urandom_range(32'h0002_0000));
      send_idle  = idle_s[ph % 4];
      recv_stall = idle_r[ph % 4];
      for (int i = 0; i < 142; i++) random_item();
      drain();
    end

    if (sb.errors == 0) $display("cic_density_grid_3d_unit: match");
    else $display("cic_density_grid_3d_unit: mismatch");
    $finish;
  end

  initial begin
    #2s;
    $display("cic_density_grid_3d_unit: mismatch");
    $finish;
  end
endmodule
